FILE: hw/rtl/svg_pkg.sv
// Shared types, constants and helper functions for the UV-sphere vertex generator.
package svg_pkg;

    localparam int IDX_W      = 10;
    localparam int CNT_W      = 10;
    localparam int RAD_W      = 16;
    localparam int POS_W      = 17;
    localparam int NRM_W      = 16;
    localparam int TEX_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int COUNT_MAX = 1023;

    // Long division: one integer bit, then DIV_FRAC fraction bits, DIV_PER bits per stage.
    localparam int DIV_FRAC   = 32;
    localparam int DIV_PER    = 4;
    localparam int DIV_STAGES = DIV_FRAC / DIV_PER;
    localparam int QUO_W      = DIV_FRAC + 1;

    localparam int PH_W     = 32;
    localparam int CW       = 34;
    localparam int TRIG_W   = 32;
    localparam int ATAN_LEN = 24;

    localparam int NLANE     = 2;
    localparam int LANE_RING = 0;
    localparam int LANE_SEG  = 1;

    localparam logic signed [CW-1:0]     GAIN_Q30 = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30  = 32'sd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_RINGS  = 2'd1,
        REG_SEGS   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [TEX_W-1:0] tex_s;
        logic [TEX_W-1:0] tex_t;
    } tex_pair_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [TEX_W-1:0]        tex_s;
        logic [TEX_W-1:0]        tex_t;
    } vertex_t;

    // Arctangent of 2^-k in turns, unsigned Q0.32.
    function automatic logic [PH_W-1:0] atan_turn(input int k);
        logic [PH_W-1:0] a;
        case (k)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85053908;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
        logic signed [TRIG_W-1:0] r;
        if (v > CW'(ONE_Q30))
            r = ONE_Q30;
        else if (v < -CW'(ONE_Q30))
            r = -ONE_Q30;
        else
            r = TRIG_W'(v);
        return r;
    endfunction

endpackage

FILE: hw/rtl/svg_in_if.sv
// Input channel carrying ring and segment indices.
interface svg_in_if import svg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] ring_index;
    logic [IDX_W-1:0] segment_index;

    modport source (output valid, output ring_index, output segment_index, input ready);
    modport sink (input valid, input ring_index, input segment_index, output ready);
endinterface

FILE: hw/rtl/svg_out_if.sv
// Output channel carrying one sphere vertex.
interface svg_out_if import svg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [TEX_W-1:0]        tex_s;
    logic [TEX_W-1:0]        tex_t;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output normal_x, output normal_y, output normal_z,
                    output tex_s, output tex_t, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input normal_x, input normal_y, input normal_z,
                  input tex_s, input tex_t, output ready);
endinterface

FILE: hw/rtl/svg_divider.sv
// Two-lane pipelined long divider producing index * 2^32 / count.
module svg_divider import svg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [IDX_W-1:0] num [NLANE],
    input  logic [CNT_W-1:0] den [NLANE],
    output logic             out_valid,
    output logic [QUO_W-1:0] quo [NLANE]
);

    logic [DIV_STAGES:0] v_reg;
    logic [CNT_W-1:0]    rem_reg [DIV_STAGES][NLANE];
    logic [QUO_W-1:0]    quo_reg [DIV_STAGES+1][NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DIV_STAGES-1:0], in_valid};
    end

    genvar l, s;
    generate
        for (l = 0; l < NLANE; l++)
        begin : g_lane
            // The index never exceeds the count, so the integer part is a single bit.
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (num[l] >= den[l])
                    begin
                        rem_reg[0][l] <= num[l] - den[l];
                        quo_reg[0][l] <= QUO_W'(1);
                    end
                    else
                    begin
                        rem_reg[0][l] <= num[l];
                        quo_reg[0][l] <= '0;
                    end
                end
            end

            for (s = 1; s <= DIV_STAGES; s++)
            begin : g_stage
                logic [CNT_W-1:0] r_c;
                logic [QUO_W-1:0] q_c;
                logic [CNT_W:0]   dbl;

                always_comb
                begin
                    r_c = rem_reg[s-1][l];
                    q_c = quo_reg[s-1][l];
                    dbl = '0;
                    for (int t = 0; t < DIV_PER; t++)
                    begin
                        dbl = {r_c, 1'b0};
                        if (dbl >= {1'b0, den[l]})
                        begin
                            r_c = CNT_W'(dbl - {1'b0, den[l]});
                            q_c = {q_c[QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_c = dbl[CNT_W-1:0];
                            q_c = {q_c[QUO_W-2:0], 1'b0};
                        end
                    end
                end

                if (s < DIV_STAGES)
                begin : g_rem
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                            rem_reg[s][l] <= r_c;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                        quo_reg[s][l] <= q_c;
                end
            end

            assign quo[l] = quo_reg[DIV_STAGES][l];
        end
    endgenerate

    assign out_valid = v_reg[DIV_STAGES];

endmodule

FILE: hw/rtl/svg_cordic.sv
// Two-lane pipelined rotation CORDIC giving cosine and sine of a phase in turns.
module svg_cordic import svg_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [PH_W-1:0]          phase [NLANE],
    input  tex_pair_t                in_tex,
    output logic                     out_valid,
    output logic signed [TRIG_W-1:0] cos_o [NLANE],
    output logic signed [TRIG_W-1:0] sin_o [NLANE],
    output tex_pair_t                out_tex
);

    localparam int NIT = (STEPS + 1) / 2;

    logic [NIT+1:0]           v_reg;
    logic signed [CW-1:0]     x_reg [NIT+1][NLANE];
    logic signed [CW-1:0]     y_reg [NIT+1][NLANE];
    logic signed [CW-1:0]     z_reg [NIT+1][NLANE];
    logic [1:0]               q_reg [NIT+1][NLANE];
    tex_pair_t                tex_reg [NIT+2];
    logic signed [TRIG_W-1:0] cos_reg [NLANE];
    logic signed [TRIG_W-1:0] sin_reg [NLANE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NIT:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tex_reg[0] <= in_tex;
            for (int i = 1; i < NIT + 2; i++)
                tex_reg[i] <= tex_reg[i-1];
        end
    end

    genvar l, s;
    generate
        for (l = 0; l < NLANE; l++)
        begin : g_lane
            logic [1:0]      q_c;
            logic [PH_W-1:0] res_c;

            // Nearest quadrant, leaving a signed residual within one eighth of a turn.
            always_comb
            begin
                q_c   = 2'((phase[l] + 32'h2000_0000) >> 30);
                res_c = phase[l] - {q_c, 30'b0};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[0][l] <= GAIN_Q30;
                    y_reg[0][l] <= '0;
                    z_reg[0][l] <= {{(CW-PH_W){res_c[PH_W-1]}}, res_c};
                    q_reg[0][l] <= q_c;
                end
            end

            for (s = 1; s <= NIT; s++)
            begin : g_stage
                logic signed [CW-1:0] x_c;
                logic signed [CW-1:0] y_c;
                logic signed [CW-1:0] z_c;
                logic signed [CW-1:0] nx_c;

                always_comb
                begin
                    x_c  = x_reg[s-1][l];
                    y_c  = y_reg[s-1][l];
                    z_c  = z_reg[s-1][l];
                    nx_c = x_c;
                    for (int t = 0; t < 2; t++)
                    begin
                        if (2 * (s - 1) + t < STEPS)
                        begin
                            if (!z_c[CW-1])
                            begin
                                nx_c = x_c - (y_c >>> (2 * (s - 1) + t));
                                y_c  = y_c + (x_c >>> (2 * (s - 1) + t));
                                z_c  = z_c - $signed({2'b0, atan_turn(2 * (s - 1) + t)});
                            end
                            else
                            begin
                                nx_c = x_c + (y_c >>> (2 * (s - 1) + t));
                                y_c  = y_c - (x_c >>> (2 * (s - 1) + t));
                                z_c  = z_c + $signed({2'b0, atan_turn(2 * (s - 1) + t)});
                            end
                            x_c = nx_c;
                        end
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        x_reg[s][l] <= x_c;
                        y_reg[s][l] <= y_c;
                        z_reg[s][l] <= z_c;
                        q_reg[s][l] <= q_reg[s-1][l];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    case (q_reg[NIT][l])
                        2'd0:
                        begin
                            cos_reg[l] <= clamp_unit(x_reg[NIT][l]);
                            sin_reg[l] <= clamp_unit(y_reg[NIT][l]);
                        end
                        2'd1:
                        begin
                            cos_reg[l] <= clamp_unit(-y_reg[NIT][l]);
                            sin_reg[l] <= clamp_unit(x_reg[NIT][l]);
                        end
                        2'd2:
                        begin
                            cos_reg[l] <= clamp_unit(-x_reg[NIT][l]);
                            sin_reg[l] <= clamp_unit(-y_reg[NIT][l]);
                        end
                        default:
                        begin
                            cos_reg[l] <= clamp_unit(y_reg[NIT][l]);
                            sin_reg[l] <= clamp_unit(-x_reg[NIT][l]);
                        end
                    endcase
                end
            end

            assign cos_o[l] = cos_reg[l];
            assign sin_o[l] = sin_reg[l];
        end
    endgenerate

    assign out_valid = v_reg[NIT+1];
    assign out_tex   = tex_reg[NIT+1];

endmodule

FILE: hw/rtl/svg_scale.sv
// Multiply stages turning sines and cosines into position and normal.
module svg_scale import svg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [RAD_W-1:0]         radius,
    input  logic signed [TRIG_W-1:0] cr,
    input  logic signed [TRIG_W-1:0] sr,
    input  logic signed [TRIG_W-1:0] cs,
    input  logic signed [TRIG_W-1:0] ss,
    input  tex_pair_t                in_tex,
    output logic                     out_valid,
    output vertex_t                  vtx
);

    localparam int RP_W = RAD_W + 1 + TRIG_W;
    localparam int NP_W = 2 * TRIG_W;
    localparam int XY_W = RAD_W + 3;
    localparam int PP_W = XY_W + TRIG_W;

    logic [3:0] v_reg;

    // First multiply stage.
    logic signed [RP_W-1:0]   pxy1_reg, pz1_reg;
    logic signed [NP_W-1:0]   pnx1_reg, pny1_reg;
    logic signed [NRM_W-1:0]  nz1_reg;
    logic signed [TRIG_W-1:0] cs1_reg, ss1_reg;
    tex_pair_t                tex1_reg;
    // Rounding of the first products.
    logic signed [XY_W-1:0]   xy2_reg;
    logic signed [POS_W-1:0]  pz2_reg;
    logic signed [NRM_W-1:0]  nx2_reg, ny2_reg, nz2_reg;
    logic signed [TRIG_W-1:0] cs2_reg, ss2_reg;
    tex_pair_t                tex2_reg;
    // Second multiply stage.
    logic signed [PP_W-1:0]   px3_reg, py3_reg;
    logic signed [POS_W-1:0]  pz3_reg;
    logic signed [NRM_W-1:0]  nx3_reg, ny3_reg, nz3_reg;
    tex_pair_t                tex3_reg;
    vertex_t                  vtx_reg;

    logic signed [RAD_W:0] rad_s;

    assign rad_s = $signed({1'b0, radius});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxy1_reg <= RP_W'(rad_s) * RP_W'(cr);
            pz1_reg  <= RP_W'(rad_s) * RP_W'(sr);
            pnx1_reg <= NP_W'(cr) * NP_W'(cs);
            pny1_reg <= NP_W'(cr) * NP_W'(ss);
            nz1_reg  <= NRM_W'((sr + 32'sd32768) >>> 16);
            cs1_reg  <= cs;
            ss1_reg  <= ss;
            tex1_reg <= in_tex;

            xy2_reg  <= XY_W'((pxy1_reg + 49'sd536870912) >>> 30);
            pz2_reg  <= POS_W'((pz1_reg + 49'sd536870912) >>> 30);
            nx2_reg  <= NRM_W'((pnx1_reg + 64'sd35184372088832) >>> 46);
            ny2_reg  <= NRM_W'((pny1_reg + 64'sd35184372088832) >>> 46);
            nz2_reg  <= nz1_reg;
            cs2_reg  <= cs1_reg;
            ss2_reg  <= ss1_reg;
            tex2_reg <= tex1_reg;

            px3_reg  <= PP_W'(xy2_reg) * PP_W'(cs2_reg);
            py3_reg  <= PP_W'(xy2_reg) * PP_W'(ss2_reg);
            pz3_reg  <= pz2_reg;
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            nz3_reg  <= nz2_reg;
            tex3_reg <= tex2_reg;

            vtx_reg.pos_x    <= POS_W'((px3_reg + 51'sd536870912) >>> 30);
            vtx_reg.pos_y    <= POS_W'((py3_reg + 51'sd536870912) >>> 30);
            vtx_reg.pos_z    <= pz3_reg;
            vtx_reg.normal_x <= nx3_reg;
            vtx_reg.normal_y <= ny3_reg;
            vtx_reg.normal_z <= nz3_reg;
            vtx_reg.tex_s    <= tex3_reg.tex_s;
            vtx_reg.tex_t    <= tex3_reg.tex_t;
        end
    end

    assign out_valid = v_reg[3];
    assign vtx       = vtx_reg;

endmodule

FILE: hw/rtl/uv_sphere_vertex_generator_unit.sv
// UV-sphere vertex generator: one index pair in per clock unless stalled, one vertex out
// per pair. The block accepts one ring/segment index pair every clock cycle while the
// output buffer has room and returns one vertex for each, in order. An item passes
// through one clamp and integer stage and eight stages of a long divider that forms
// the phases, one quadrant stage, the CORDIC stages at two of the CORDIC_STEPS
// iterations (16 by default) each, one quadrant rotation stage, four multiply and
// rounding stages, and a two-entry output buffer. The pipeline stops only when that
// buffer is full; while it has room, input is taken even if a vertex is waiting.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while the block holds no item; the block itself does not enforce it.
module uv_sphere_vertex_generator_unit import svg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    svg_in_if.sink                vtx_in,
    svg_out_if.source             vtx_out
);

    logic [RAD_W-1:0] radius_reg;
    logic [CNT_W-1:0] ring_count_reg;
    logic [CNT_W-1:0] segment_count_reg;

    function automatic logic [CNT_W-1:0] limit_count(input logic [CFG_DATA_W-1:0] v);
        logic [CNT_W-1:0] c;
        c = v[CNT_W-1:0];
        if (int'(c) > COUNT_MAX)
            c = CNT_W'(COUNT_MAX);
        return c;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg        <= RAD_W'(256);
            ring_count_reg    <= CNT_W'(16);
            segment_count_reg <= CNT_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RADIUS: radius_reg        <= cfg_data[RAD_W-1:0];
                REG_RINGS:  ring_count_reg    <= limit_count(cfg_data);
                REG_SEGS:   segment_count_reg <= limit_count(cfg_data);
                default:    ;
            endcase
        end
    end

    logic [CNT_W-1:0] rings_eff, segs_eff;
    logic [IDX_W-1:0] num [NLANE];
    logic [CNT_W-1:0] den [NLANE];
    logic             adv;

    assign rings_eff = (ring_count_reg == '0) ? CNT_W'(1) : ring_count_reg;
    assign segs_eff  = (segment_count_reg == '0) ? CNT_W'(1) : segment_count_reg;

    assign num[LANE_RING] = (vtx_in.ring_index > rings_eff) ? rings_eff : vtx_in.ring_index;
    assign num[LANE_SEG]  = (vtx_in.segment_index > segs_eff) ? segs_eff
                                                               : vtx_in.segment_index;
    assign den[LANE_RING] = rings_eff;
    assign den[LANE_SEG]  = segs_eff;

    logic             div_valid;
    logic [QUO_W-1:0] quo [NLANE];

    svg_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vtx_in.valid),
        .num       (num),
        .den       (den),
        .out_valid (div_valid),
        .quo       (quo)
    );

    // The ring angle is a quarter turn less half a turn scaled by i/rings.
    logic [PH_W-1:0] phase [NLANE];
    tex_pair_t       div_tex;

    assign phase[LANE_SEG]  = quo[LANE_SEG][PH_W-1:0];
    assign phase[LANE_RING] = 32'h4000_0000 - quo[LANE_RING][QUO_W-1:1];
    assign div_tex.tex_s    = TEX_W'(({1'b0, quo[LANE_SEG]} + 34'd32768) >> 16);
    assign div_tex.tex_t    = TEX_W'(({1'b0, quo[LANE_RING]} + 34'd32768) >> 16);

    logic                     cor_valid;
    logic signed [TRIG_W-1:0] cos_v [NLANE];
    logic signed [TRIG_W-1:0] sin_v [NLANE];
    tex_pair_t                cor_tex;

    svg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .phase     (phase),
        .in_tex    (div_tex),
        .out_valid (cor_valid),
        .cos_o     (cos_v),
        .sin_o     (sin_v),
        .out_tex   (cor_tex)
    );

    logic    sc_valid;
    vertex_t sc_vtx;

    svg_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cor_valid),
        .radius    (radius_reg),
        .cr        (cos_v[LANE_RING]),
        .sr        (sin_v[LANE_RING]),
        .cs        (cos_v[LANE_SEG]),
        .ss        (sin_v[LANE_SEG]),
        .in_tex    (cor_tex),
        .out_valid (sc_valid),
        .vtx       (sc_vtx)
    );

    // Two-entry output buffer; the pipeline advances whenever it is not full.
    vertex_t    fifo_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    vertex_t    head;

    assign adv  = (cnt_reg != 2'd2);
    assign push = adv && sc_valid;
    assign pop  = vtx_out.valid && vtx_out.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem_reg[wr_ptr_reg] <= sc_vtx;
    end

    assign head = fifo_mem_reg[rd_ptr_reg];

    assign vtx_in.ready     = adv;
    assign vtx_out.valid    = (cnt_reg != 2'd0);
    assign vtx_out.pos_x    = head.pos_x;
    assign vtx_out.pos_y    = head.pos_y;
    assign vtx_out.pos_z    = head.pos_z;
    assign vtx_out.normal_x = head.normal_x;
    assign vtx_out.normal_y = head.normal_y;
    assign vtx_out.normal_z = head.normal_z;
    assign vtx_out.tex_s    = head.tex_s;
    assign vtx_out.tex_t    = head.tex_t;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(sc_valid && cnt_reg == 2'd2 && !adv && push))
        else $error("output buffer written while full");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (sc_vtx.normal_z >= -16'sd16384 && sc_vtx.normal_z <= 16'sd16384))
        else $error("normal z outside unit range");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (sc_vtx.tex_s <= 17'd65536 && sc_vtx.tex_t <= 17'd65536))
        else $error("texture coordinate above one");

endmodule
